// ===== hdl/qmt_pkg.sv =====
// Shared definitions for the quorum membership table: widths, defaults,
// command and register codes, state types and the result record.
// No dependencies.
package qmt_pkg;

  localparam int unsigned MaxSeeds     = 8;
  localparam int unsigned TableEntries = 64;

  localparam int unsigned KeyW     = 48;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned SeedIdxW = 3;
  localparam int unsigned SeedCntW = 4;
  localparam int unsigned CountW   = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 4;

  localparam logic [SeedCntW-1:0] SeedCountReset = SeedCntW'(3);
  localparam logic [SeedIdxW-1:0] OwnSeedReset   = SeedIdxW'(0);
  localparam logic [CountW-1:0]   CountMax       = '1;

  typedef enum logic [CmdW-1:0] {
    CmdLocalJoin,
    CmdJoinVote,
    CmdLocalDead,
    CmdDeadVote
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSeedCount,
    CfgOwnSeed
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TopIdle,
    TopSearch,
    TopUpdate,
    TopOut
  } top_state_e;

  typedef enum logic {
    SrchIdle,
    SrchScan
  } srch_state_e;

  typedef enum logic [1:0] {
    UpIdle,
    UpMerge,
    UpCount
  } upd_state_e;

  typedef struct packed {
    logic done;
    logic full;
    logic fresh;
  } srch_status_t;

  typedef struct packed {
    logic              is_member;
    logic [CountW-1:0] vote_count;
    logic              quorum_reached;
    logic              peer_added;
    logic              peer_removed;
    logic              table_full;
  } result_t;

endpackage

// ===== hdl/qmt_key_search.sv =====
// Key memory with fill count and a sequential lookup that allocates on a miss while not full.
// Depends on qmt_pkg.
module qmt_key_search #(
  parameter int unsigned TableEntries = qmt_pkg::TableEntries
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [qmt_pkg::KeyW-1:0]          key_i,
  output qmt_pkg::srch_status_t             status_o,
  output logic [$clog2(TableEntries)-1:0]   idx_o
);
  import qmt_pkg::*;

  localparam int unsigned IdxW  = $clog2(TableEntries);
  localparam int unsigned FillW = $clog2(TableEntries + 1);

  logic [KeyW-1:0]  key_mem [TableEntries];
  logic [KeyW-1:0]  rd_key_q;
  logic [IdxW-1:0]  rd_addr;
  logic             wr_en;

  srch_state_e      state_q, state_d;
  logic [IdxW-1:0]  ptr_q, ptr_d;
  logic [FillW-1:0] fill_q, fill_d;

  logic [FillW-1:0] ptr_ext;
  logic             in_range;
  logic             match;
  logic             last;
  logic             full;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[fill_q[IdxW-1:0]] <= key_i;
    end
    rd_key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SrchIdle;
      ptr_q   <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      fill_q  <= fill_d;
    end
  end

  assign ptr_ext  = FillW'(ptr_q);
  assign in_range = ptr_ext < fill_q;
  assign match    = in_range && (rd_key_q == key_i);
  assign last     = (ptr_ext + FillW'(1)) >= fill_q;
  assign full     = fill_q == FillW'(TableEntries);

  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    fill_d   = fill_q;
    rd_addr  = IdxW'(ptr_q + IdxW'(1));
    wr_en    = 1'b0;
    status_o = '0;
    idx_o    = ptr_q;
    case (state_q)
      SrchIdle: begin
        rd_addr = '0;
        if (start_i) begin
          ptr_d   = '0;
          state_d = SrchScan;
        end
      end
      SrchScan: begin
        if (match) begin
          status_o.done = 1'b1;
          state_d       = SrchIdle;
        end else if (last) begin
          status_o.done = 1'b1;
          state_d       = SrchIdle;
          if (full) begin
            status_o.full = 1'b1;
          end else begin
            status_o.fresh = 1'b1;
            idx_o          = fill_q[IdxW-1:0];
            wr_en          = 1'b1;
            fill_d         = fill_q + FillW'(1);
          end
        end else begin
          ptr_d = ptr_q + IdxW'(1);
        end
      end
      default: begin
        state_d = SrchIdle;
      end
    endcase
  end

endmodule

// ===== hdl/qmt_vote_update.sv =====
// Entry memory holding membership flag and both vote bitmaps, with the
// read-modify-write step that records a vote and applies the quorum rule.
// Depends on qmt_pkg.
module qmt_vote_update #(
  parameter int unsigned MaxSeeds     = qmt_pkg::MaxSeeds,
  parameter int unsigned TableEntries = qmt_pkg::TableEntries
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [$clog2(TableEntries)-1:0]     idx_i,
  input  logic                                fresh_i,
  input  qmt_pkg::cmd_e                       cmd_i,
  input  logic [qmt_pkg::SeedIdxW-1:0]        voter_i,
  input  logic [qmt_pkg::SeedIdxW-1:0]        own_seed_i,
  input  logic [qmt_pkg::SeedCntW-1:0]        quorum_i,
  output logic                                done_o,
  output qmt_pkg::result_t                    result_o
);
  import qmt_pkg::*;

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned RecW = 2 * MaxSeeds + 1;
  localparam int unsigned PcW  = $clog2(MaxSeeds + 1);

  logic [RecW-1:0]     ent_mem [TableEntries];
  logic [RecW-1:0]     rd_rec_q;
  logic                wr_en;
  logic [RecW-1:0]     wr_rec;

  upd_state_e          state_q, state_d;
  logic [IdxW-1:0]     idx_q;
  logic                fresh_q;
  logic                member_q, member_d;
  logic [MaxSeeds-1:0] join_q, join_d;
  logic [MaxSeeds-1:0] dead_q, dead_d;

  logic [RecW-1:0]     rec;
  logic [SeedIdxW-1:0] sel_idx;
  logic [MaxSeeds-1:0] seed_bit;
  logic                is_join;
  logic                checked;
  logic [MaxSeeds-1:0] touched;
  logic [PcW-1:0]      pop;
  logic                reached;
  logic                member_new;
  logic [MaxSeeds-1:0] dead_new;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ent_mem[idx_q] <= wr_rec;
    end
    rd_rec_q <= ent_mem[idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= UpIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == UpIdle && start_i) begin
      idx_q   <= idx_i;
      fresh_q <= fresh_i;
    end
    member_q <= member_d;
    join_q   <= join_d;
    dead_q   <= dead_d;
  end

  assign is_join = (cmd_i == CmdLocalJoin) || (cmd_i == CmdJoinVote);
  assign checked = (cmd_i == CmdJoinVote) || (cmd_i == CmdDeadVote);
  assign sel_idx = checked ? voter_i : own_seed_i;
  assign rec     = fresh_q ? '0 : rd_rec_q;
  assign touched = is_join ? join_q : dead_q;

  always_comb begin
    seed_bit = '0;
    if (32'(sel_idx) < MaxSeeds) begin
      seed_bit = MaxSeeds'(1) << sel_idx;
    end
  end

  always_comb begin
    pop = '0;
    for (int unsigned b = 0; b < MaxSeeds; b++) begin
      pop = pop + PcW'(touched[b]);
    end
  end

  assign reached = checked && (32'(pop) >= 32'(quorum_i));

  always_comb begin
    member_new = member_q;
    dead_new   = dead_q;
    if (reached) begin
      if (is_join) begin
        member_new = 1'b1;
      end else begin
        member_new = 1'b0;
        dead_new   = '0;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    member_d = member_q;
    join_d   = join_q;
    dead_d   = dead_q;
    wr_en    = 1'b0;
    wr_rec   = {member_new, join_q, dead_new};
    done_o   = 1'b0;
    result_o = '0;
    case (state_q)
      UpIdle: begin
        if (start_i) begin
          state_d = UpMerge;
        end
      end
      UpMerge: begin
        member_d = rec[RecW-1];
        join_d   = rec[2*MaxSeeds-1:MaxSeeds];
        dead_d   = rec[MaxSeeds-1:0];
        if (is_join) begin
          join_d = rec[2*MaxSeeds-1:MaxSeeds] | seed_bit;
        end else begin
          dead_d = rec[MaxSeeds-1:0] | seed_bit;
        end
        state_d = UpCount;
      end
      UpCount: begin
        wr_en                   = 1'b1;
        done_o                  = 1'b1;
        result_o.is_member      = member_new;
        result_o.vote_count     = (32'(pop) > 32'(CountMax)) ? CountMax : CountW'(pop);
        result_o.quorum_reached = reached;
        result_o.peer_added     = member_new && !member_q;
        result_o.peer_removed   = member_q && !member_new;
        state_d                 = UpIdle;
      end
      default: begin
        state_d = UpIdle;
      end
    endcase
  end

endmodule

// ===== hdl/quorum_membership_table_unit.sv =====
// Top level of the quorum membership table: configuration registers,
// transaction handshakes, control sequencing and the result register.
// Depends on qmt_pkg, qmt_key_search and qmt_vote_update.
//
// Usage: an input transaction carries a command, a 48-bit peer key and a
// voter index; each one yields exactly one output transaction. in_ready_o is
// high only while no transaction is in progress; the block works on one
// transaction at a time.
// Timing: the key memory is scanned one entry per cycle through its single
// read port. The next input can be accepted in the same cycle in which the
// result becomes valid. A miss scans all allocated entries and, unless the
// table is full, allocates a new one; a miss on a full table skips the
// entry update. The worst case is a key held in the last entry of a full
// table. The entry read and write-back follow the scan in the merge and
// count steps of the update.
// Configuration writes take effect at the clock edge that carries them and
// must only be issued while no transaction is in flight.
// Reset clears the fill count, so every entry reads as unallocated, and
// loads the default seed count and own seed index; no memory pass is needed.
// Backpressure: the result sits in an output register until out_ready_i is
// high. A new transaction is accepted meanwhile, and its result waits in
// the sequencer until the register is free.
module quorum_membership_table_unit #(
  parameter int unsigned MaxSeeds     = qmt_pkg::MaxSeeds,
  parameter int unsigned TableEntries = qmt_pkg::TableEntries
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qmt_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [qmt_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [qmt_pkg::CmdW-1:0]       command_i,
  input  logic [qmt_pkg::KeyW-1:0]       peer_key_i,
  input  logic [qmt_pkg::SeedIdxW-1:0]   voter_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           is_member_o,
  output logic [qmt_pkg::CountW-1:0]     vote_count_o,
  output logic                           quorum_reached_o,
  output logic                           peer_added_o,
  output logic                           peer_removed_o,
  output logic                           table_full_o
);
  import qmt_pkg::*;

  localparam int unsigned IdxW = $clog2(TableEntries);

  logic [SeedCntW-1:0] seed_count_q;
  logic [SeedIdxW-1:0] own_seed_q;
  logic [SeedCntW-1:0] quorum;

  top_state_e          state_q, state_d;
  cmd_e                cmd_q;
  logic [KeyW-1:0]     key_q;
  logic [SeedIdxW-1:0] voter_q;
  result_t             res_q, res_d;
  result_t             out_q;
  logic                out_valid_q, out_valid_d;
  logic                out_load;

  logic                accept;
  srch_status_t        srch_status;
  logic [IdxW-1:0]     srch_idx;
  logic                upd_start;
  logic                upd_done;
  result_t             upd_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_count_q <= SeedCountReset;
      own_seed_q   <= OwnSeedReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgSeedCount: seed_count_q <= cfg_data_i[SeedCntW-1:0];
        CfgOwnSeed:   own_seed_q   <= cfg_data_i[SeedIdxW-1:0];
        default:      ;
      endcase
    end
  end

  assign quorum = (seed_count_q >> 1) + SeedCntW'(1);

  assign in_ready_o = state_q == TopIdle;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(command_i);
      key_q   <= peer_key_i;
      voter_q <= voter_index_i;
    end
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TopIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  qmt_key_search #(
    .TableEntries(TableEntries)
  ) u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .key_i   (key_q),
    .status_o(srch_status),
    .idx_o   (srch_idx)
  );

  qmt_vote_update #(
    .MaxSeeds    (MaxSeeds),
    .TableEntries(TableEntries)
  ) u_update (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (upd_start),
    .idx_i     (srch_idx),
    .fresh_i   (srch_status.fresh),
    .cmd_i     (cmd_q),
    .voter_i   (voter_q),
    .own_seed_i(own_seed_q),
    .quorum_i  (quorum),
    .done_o    (upd_done),
    .result_o  (upd_result)
  );

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    upd_start   = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      TopIdle: begin
        if (accept) begin
          state_d = TopSearch;
        end
      end
      TopSearch: begin
        if (srch_status.done) begin
          if (srch_status.full) begin
            res_d            = '0;
            res_d.table_full = 1'b1;
            state_d          = TopOut;
          end else begin
            upd_start = 1'b1;
            state_d   = TopUpdate;
          end
        end
      end
      TopUpdate: begin
        if (upd_done) begin
          res_d   = upd_result;
          state_d = TopOut;
        end
      end
      TopOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = TopIdle;
        end
      end
      default: begin
        state_d = TopIdle;
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign is_member_o      = out_q.is_member;
  assign vote_count_o     = out_q.vote_count;
  assign quorum_reached_o = out_q.quorum_reached;
  assign peer_added_o     = out_q.peer_added;
  assign peer_removed_o   = out_q.peer_removed;
  assign table_full_o     = out_q.table_full;

endmodule
